// File: rtl/core/ipv4_fragment_reassembly_tracker_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fragment reassembly tracker
// Shared property forms used by the ifr_back module.
// ----------------------------------------------------------------------------
`ifndef IPV4_FRAGMENT_REASSEMBLY_TRACKER_DEFINES_SVH
`define IPV4_FRAGMENT_REASSEMBLY_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IFR_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IFR_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ifr_pkg.sv
// ----------------------------------------------------------------------------
// ifr_pkg
// Types and constants shared by the fragment reassembly tracker.
// ----------------------------------------------------------------------------
package ifr_pkg;

    localparam int CONTEXTS_DEF = 8;
    localparam int FRAGS_DEF    = 8;
    localparam logic [7:0] TIMEOUT_RESET = 8'd10;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_DUP      = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_COMPLETE = 3'd3,
        ST_TICK     = 3'd4
    } status_t;

    // One input word.
    typedef struct packed {
        logic        mode;
        logic [31:0] src_addr;
        logic [15:0] datagram_id;
        logic [12:0] frag_offset;
        logic [15:0] data_len;
        logic        more_frags;
    } item_t;

    // One stored fragment range.
    typedef struct packed {
        logic [15:0] start_b;
        logic [16:0] stop_b;
        logic        more;
    } slot_t;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_LOOKUP,
        BS_TICK,
        BS_SCAN_RD,
        BS_SCAN_CHK,
        BS_SHIFT_RD,
        BS_SHIFT_WR,
        BS_INSERT,
        BS_CHK_RD,
        BS_CHK_EVAL
    } back_state_t;

endpackage

// File: rtl/core/ifr_ram.sv
// ----------------------------------------------------------------------------
// ifr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ifr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/ifr_front.sv
// ----------------------------------------------------------------------------
// ifr_front
// Accepts command words and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ifr_front
    import ifr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  item_t       item_in,
    output queue_head_t head,
    input  logic        pop
);

    logic [1:0] count_reg, count_next;
    item_t      ent0_reg, ent0_next;
    item_t      ent1_reg, ent1_next;
    logic       push;

    assign busy = (count_reg == 2'd2);
    assign push = start && !busy;
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = ent0_reg;

    // Queue control: entry 0 is always the head.
    always_comb
    begin
        count_next = count_reg;
        ent0_next  = ent0_reg;
        ent1_next  = ent1_reg;
        if (pop && head.valid)
        begin
            ent0_next = ent1_reg;
            if (push)
            begin
                if (count_reg == 2'd1)
                begin
                    ent0_next = item_in;
                end
                else
                begin
                    ent1_next = item_in;
                end
            end
            else
            begin
                count_next = count_reg - 2'd1;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                ent0_next = item_in;
            end
            else
            begin
                ent1_next = item_in;
            end
            count_next = count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

endmodule

// File: rtl/core/ifr_back.sv
// ----------------------------------------------------------------------------
// ifr_back
// Context table, recency order and the sequencer that walks fragment slots.
// ----------------------------------------------------------------------------
`include "ipv4_fragment_reassembly_tracker_defines.svh"

module ifr_back
    import ifr_pkg::*;
#(
    parameter int CONTEXTS = CONTEXTS_DEF,
    parameter int FRAGS_PER_DATAGRAM = FRAGS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  timeout_ticks,
    input  queue_head_t head,
    output logic        pop,
    output logic        done,
    output logic [2:0]  status,
    output logic [2:0]  context_index,
    output logic        evicted,
    output logic [16:0] payload_len,
    output logic [3:0]  expired_count
);

    localparam int CW    = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
    localparam int NW    = $clog2(FRAGS_PER_DATAGRAM + 1);
    localparam int DEPTH = CONTEXTS * FRAGS_PER_DATAGRAM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = $bits(slot_t);

    typedef logic [CONTEXTS-1:0][CW-1:0] rank_vec_t;

    // Context table.
    logic [CONTEXTS-1:0]          valid_reg, valid_next;
    logic [CONTEXTS-1:0][31:0]    src_reg, src_next;
    logic [CONTEXTS-1:0][15:0]    ident_reg, ident_next;
    logic [CONTEXTS-1:0][7:0]     timer_reg, timer_next;
    rank_vec_t                    rank_reg, rank_next;
    logic [CONTEXTS-1:0][NW-1:0]  count_reg, count_next;

    // Sequencer.
    back_state_t  state_reg, state_next;
    item_t        item_reg, item_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] k_reg, k_next;
    logic [NW-1:0] pos_reg, pos_next;
    logic [16:0]   acc_reg, acc_next;
    logic          ev_reg, ev_next;
    logic [3:0]    exp_reg, exp_next;

    // Result registers.
    logic        done_reg, done_next;
    status_t     status_reg, status_next;
    logic [2:0]  cidx_reg, cidx_next;
    logic        evicted_reg, evicted_next;
    logic [16:0] payload_reg, payload_next;
    logic [3:0]  expired_reg, expired_next;

    // Slot memory.
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    slot_t         ram_wdata, ram_rdata;
    logic [SW-1:0] ram_rbits;

    ifr_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );

    assign ram_rdata = slot_t'(ram_rbits);

    // Removes context c from the recency order.
    function automatic rank_vec_t f_release(rank_vec_t rk, logic [CONTEXTS-1:0] vl,
                                            logic [CW-1:0] c);
        rank_vec_t r;
        r = rk;
        for (int j = 0; j < CONTEXTS; j++)
        begin
            if ((CW'(j) != c) && vl[j] && (rk[j] > rk[c]))
            begin
                r[j] = rk[j] - 1'b1;
            end
        end
        r[c] = '0;
        return r;
    endfunction

    // Moves context c to the front of the recency order.
    function automatic rank_vec_t f_front(rank_vec_t rk, logic [CONTEXTS-1:0] vl,
                                          logic [CW-1:0] c);
        rank_vec_t r;
        r = rk;
        for (int j = 0; j < CONTEXTS; j++)
        begin
            if ((CW'(j) != c) && vl[j] && (rk[j] < rk[c]))
            begin
                r[j] = rk[j] + 1'b1;
            end
        end
        r[c] = '0;
        return r;
    endfunction

    // Pushes a new context c in front of all valid ones.
    function automatic rank_vec_t f_push(rank_vec_t rk, logic [CONTEXTS-1:0] vl,
                                         logic [CW-1:0] c);
        rank_vec_t r;
        r = rk;
        for (int j = 0; j < CONTEXTS; j++)
        begin
            if (vl[j])
            begin
                r[j] = rk[j] + 1'b1;
            end
        end
        r[c] = '0;
        return r;
    endfunction

    function automatic logic [AW-1:0] f_addr(logic [CW-1:0] c, logic [NW-1:0] k);
        return AW'(int'(c) * FRAGS_PER_DATAGRAM + int'(k));
    endfunction

    // Fragment range of the current word.
    logic [15:0] frag_start;
    logic [16:0] frag_stop;
    assign frag_start = {item_reg.frag_offset, 3'b000};
    assign frag_stop  = {1'b0, frag_start} + {1'b0, item_reg.data_len};

    // Context search: match, lowest free slot, least recent valid context.
    logic          match_found, free_found;
    logic [CW-1:0] match_idx, free_idx, best_idx;

    always_comb
    begin
        match_found = 1'b0;
        free_found  = 1'b0;
        match_idx   = '0;
        free_idx    = '0;
        best_idx    = '0;
        for (int i = 0; i < CONTEXTS; i++)
        begin
            if (!match_found && valid_reg[i] && (src_reg[i] == item_reg.src_addr)
                && (ident_reg[i] == item_reg.datagram_id))
            begin
                match_found = 1'b1;
                match_idx   = CW'(i);
            end
            if (!free_found && !valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = CW'(i);
            end
            if (valid_reg[i] && (rank_reg[i] >= rank_reg[best_idx]))
            begin
                best_idx = CW'(i);
            end
        end
    end

    // Sequencer next state and outputs.
    always_comb
    begin
        logic [CW-1:0] c;
        logic [NW-1:0] n;
        logic [16:0]   acc_new;
        rank_vec_t     rk;
        logic [CONTEXTS-1:0] vl;

        valid_next   = valid_reg;
        src_next     = src_reg;
        ident_next   = ident_reg;
        timer_next   = timer_reg;
        rank_next    = rank_reg;
        count_next   = count_reg;
        state_next   = state_reg;
        item_next    = item_reg;
        cur_next     = cur_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        pos_next     = pos_reg;
        acc_next     = acc_reg;
        ev_next      = ev_reg;
        exp_next     = exp_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        cidx_next    = cidx_reg;
        evicted_next = evicted_reg;
        payload_next = payload_reg;
        expired_next = expired_reg;
        pop          = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = f_addr(cur_reg, k_reg);
        ram_wdata    = ram_rdata;
        ram_raddr    = f_addr(cur_reg, k_reg);
        c            = cur_reg;
        n            = n_reg;
        acc_new      = acc_reg + (ram_rdata.stop_b - {1'b0, ram_rdata.start_b});
        rk           = rank_reg;
        vl           = valid_reg;

        unique case (state_reg)
            BS_IDLE:
            begin
                if (head.valid)
                begin
                    pop       = 1'b1;
                    item_next = head.item;
                    cur_next  = '0;
                    exp_next  = '0;
                    ev_next   = 1'b0;
                    state_next = head.item.mode ? BS_TICK : BS_LOOKUP;
                end
            end

            // Age one context per cycle.
            BS_TICK:
            begin
                if (valid_reg[cur_reg])
                begin
                    if (timer_reg[cur_reg] <= 8'd1)
                    begin
                        rank_next           = f_release(rank_reg, valid_reg, cur_reg);
                        valid_next[cur_reg] = 1'b0;
                        count_next[cur_reg] = '0;
                        if (exp_reg != 4'd15)
                        begin
                            exp_next = exp_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        timer_next[cur_reg] = timer_reg[cur_reg] - 8'd1;
                    end
                end
                cur_next = cur_reg + 1'b1;
                if (cur_reg == CW'(CONTEXTS - 1))
                begin
                    done_next    = 1'b1;
                    status_next  = ST_TICK;
                    cidx_next    = 3'd0;
                    evicted_next = 1'b0;
                    payload_next = '0;
                    expired_next = (valid_reg[cur_reg] && (timer_reg[cur_reg] <= 8'd1)
                                    && (exp_reg != 4'd15)) ? exp_reg + 4'd1 : exp_reg;
                    state_next   = BS_IDLE;
                end
            end

            // Find or allocate the context and update the recency order.
            BS_LOOKUP:
            begin
                if (match_found)
                begin
                    c  = match_idx;
                    rk = f_front(rank_reg, valid_reg, c);
                    n  = count_reg[c];
                end
                else
                begin
                    if (free_found)
                    begin
                        c = free_idx;
                    end
                    else
                    begin
                        c     = best_idx;
                        rk    = f_release(rk, vl, c);
                        vl[c] = 1'b0;
                        ev_next = 1'b1;
                    end
                    src_next[c]   = item_reg.src_addr;
                    ident_next[c] = item_reg.datagram_id;
                    timer_next[c] = timeout_ticks;
                    rk    = f_push(rk, vl, c);
                    vl[c] = 1'b1;
                    n     = '0;
                end
                count_next[c] = n;
                cur_next = c;
                n_next   = n;
                k_next   = '0;
                pos_next = n;
                cidx_next = 3'(7'(c));
                if (n >= NW'(FRAGS_PER_DATAGRAM))
                begin
                    rk            = f_release(rk, vl, c);
                    vl[c]         = 1'b0;
                    count_next[c] = '0;
                    done_next     = 1'b1;
                    status_next   = ST_OVERFLOW;
                    evicted_next  = ev_next;
                    payload_next  = '0;
                    expired_next  = '0;
                    state_next    = BS_IDLE;
                end
                else if (n == '0)
                begin
                    state_next = BS_INSERT;
                end
                else
                begin
                    state_next = BS_SCAN_RD;
                end
                rank_next  = rk;
                valid_next = vl;
            end

            BS_SCAN_RD:
            begin
                state_next = BS_SCAN_CHK;
            end

            // Compare against the stored range just read.
            BS_SCAN_CHK:
            begin
                if (frag_start == ram_rdata.start_b)
                begin
                    done_next    = 1'b1;
                    status_next  = ST_DUP;
                    evicted_next = ev_reg;
                    payload_next = '0;
                    expired_next = '0;
                    state_next   = BS_IDLE;
                end
                else if (frag_stop <= {1'b0, ram_rdata.start_b})
                begin
                    pos_next   = k_reg;
                    k_next     = n_reg;
                    state_next = (n_reg == k_reg) ? BS_INSERT : BS_SHIFT_RD;
                end
                else if (k_reg + 1'b1 == n_reg)
                begin
                    pos_next   = n_reg;
                    k_next     = n_reg;
                    state_next = BS_INSERT;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = BS_SCAN_RD;
                end
            end

            BS_SHIFT_RD:
            begin
                ram_raddr  = f_addr(cur_reg, k_reg - 1'b1);
                state_next = BS_SHIFT_WR;
            end

            // Move one range up by one slot.
            BS_SHIFT_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = f_addr(cur_reg, k_reg);
                ram_wdata  = ram_rdata;
                k_next     = k_reg - 1'b1;
                state_next = (k_reg - 1'b1 == pos_reg) ? BS_INSERT : BS_SHIFT_RD;
            end

            BS_INSERT:
            begin
                ram_we            = 1'b1;
                ram_waddr         = f_addr(cur_reg, pos_reg);
                ram_wdata.start_b = frag_start;
                ram_wdata.stop_b  = frag_stop;
                ram_wdata.more    = item_reg.more_frags;
                n_next            = n_reg + 1'b1;
                count_next[cur_reg] = n_reg + 1'b1;
                k_next            = '0;
                acc_next          = '0;
                state_next        = BS_CHK_RD;
            end

            BS_CHK_RD:
            begin
                state_next = BS_CHK_EVAL;
            end

            // Walk the ranges from byte 0 to test for completion.
            BS_CHK_EVAL:
            begin
                if ({1'b0, ram_rdata.start_b} != acc_reg)
                begin
                    done_next    = 1'b1;
                    status_next  = ST_STORED;
                    evicted_next = ev_reg;
                    payload_next = '0;
                    expired_next = '0;
                    state_next   = BS_IDLE;
                end
                else if (k_reg + 1'b1 == n_reg)
                begin
                    done_next    = 1'b1;
                    evicted_next = ev_reg;
                    expired_next = '0;
                    state_next   = BS_IDLE;
                    if (!ram_rdata.more)
                    begin
                        rank_next           = f_release(rank_reg, valid_reg, cur_reg);
                        valid_next[cur_reg] = 1'b0;
                        count_next[cur_reg] = '0;
                        status_next         = ST_COMPLETE;
                        payload_next        = acc_new;
                    end
                    else
                    begin
                        status_next  = ST_STORED;
                        payload_next = '0;
                    end
                end
                else
                begin
                    acc_next   = acc_new;
                    k_next     = k_reg + 1'b1;
                    state_next = BS_CHK_RD;
                end
            end

            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BS_IDLE;
            valid_reg <= '0;
            rank_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg     <= src_next;
        ident_reg   <= ident_next;
        timer_reg   <= timer_next;
        item_reg    <= item_next;
        cur_reg     <= cur_next;
        n_reg       <= n_next;
        k_reg       <= k_next;
        pos_reg     <= pos_next;
        acc_reg     <= acc_next;
        ev_reg      <= ev_next;
        exp_reg     <= exp_next;
        status_reg  <= status_next;
        cidx_reg    <= cidx_next;
        evicted_reg <= evicted_next;
        payload_reg <= payload_next;
        expired_reg <= expired_next;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign context_index = cidx_reg;
    assign evicted       = evicted_reg;
    assign payload_len   = payload_reg;
    assign expired_count = expired_reg;

    `IFR_ASSERT_IMP(a_payload_only_complete, clk, rst_n,
        done && (status != ST_COMPLETE), payload_len == 17'd0,
        "payload length reported on an incomplete result")
    `IFR_ASSERT_IMP(a_tick_fields, clk, rst_n,
        done && (status == ST_TICK), !evicted && (context_index == 3'd0),
        "tick result carries fragment fields")
    `IFR_ASSERT_NXT(a_idle_takes_head, clk, rst_n,
        (state_reg == BS_IDLE) && head.valid,
        (state_reg == BS_LOOKUP) || (state_reg == BS_TICK),
        "queued word not taken by an idle back end")

endmodule

// File: rtl/core/ipv4_fragment_reassembly_tracker.sv
// The back end handles one word at a time and takes the next queued word in the cycle in which
// the previous result shows. A two-word queue accepts commands meanwhile; busy shows it full.
// Results last one cycle on done and cannot be stalled.
// Reset clears all contexts and the queue at once; the timeout register returns to 10.
// ----------------------------------------------------------------------------
// ipv4_fragment_reassembly_tracker
// Top level: command queue, context sequencer and timeout register.
// ----------------------------------------------------------------------------
module ipv4_fragment_reassembly_tracker
    import ifr_pkg::*;
#(
    parameter int CONTEXTS = CONTEXTS_DEF,
    parameter int FRAGS_PER_DATAGRAM = FRAGS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [31:0] src_addr,
    input  logic [15:0] datagram_id,
    input  logic [12:0] frag_offset,
    input  logic [15:0] data_len,
    input  logic        more_frags,
    output logic        done,
    output logic [2:0]  status,
    output logic [2:0]  context_index,
    output logic        evicted,
    output logic [16:0] payload_len,
    output logic [3:0]  expired_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic [7:0]  timeout_reg, timeout_next;
    item_t       item_in;
    queue_head_t head;
    logic        pop;

    // Timeout register write.
    assign cfg_ready    = 1'b1;
    assign timeout_next = (cfg_valid && cfg_ready) ? cfg_data : timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
        end
    end

    assign item_in.mode        = mode;
    assign item_in.src_addr    = src_addr;
    assign item_in.datagram_id = datagram_id;
    assign item_in.frag_offset = frag_offset;
    assign item_in.data_len    = data_len;
    assign item_in.more_frags  = more_frags;

    ifr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item_in (item_in),
        .head    (head),
        .pop     (pop)
    );

    ifr_back #(
        .CONTEXTS           (CONTEXTS),
        .FRAGS_PER_DATAGRAM (FRAGS_PER_DATAGRAM)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .timeout_ticks (timeout_reg),
        .head          (head),
        .pop           (pop),
        .done          (done),
        .status        (status),
        .context_index (context_index),
        .evicted       (evicted),
        .payload_len   (payload_len),
        .expired_count (expired_count)
    );

endmodule
